[design/tscl_pkg.sv]
// ----------------------------------------------------------------------------
// tscl_pkg
// Shared widths, constants, side-band type and tanh table for the soft limiter.
// ----------------------------------------------------------------------------
package tscl_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
  localparam int MAG_W        = SAMPLE_WIDTH;

  localparam int TANH_ENTRIES = 256;
  localparam int ROM_W        = 16;
  localparam int TANH_FRAC    = 15;
  localparam int IDX_W        = $clog2(TANH_ENTRIES + 1);

  localparam int THRESH_W = 15;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd29491;
  localparam int KNEE_LSH = (FRAC_BITS >= THRESH_W) ? FRAC_BITS - THRESH_W : 0;
  localparam int KNEE_RSH = (FRAC_BITS < THRESH_W) ? THRESH_W - FRAC_BITS : 0;

  localparam int ARG_FRAC  = 12;
  localparam int ARG_SHIFT = ARG_FRAC + 1;
  localparam int ARG_W     = 16;
  localparam int QUOT_W    = ARG_W;
  localparam int NUM_W     = MAG_W + ARG_SHIFT + 1;
  localparam int DEN_W     = MAG_W + 1;
  localparam int CMP_W     = DEN_W + QUOT_W;

  localparam logic [MAG_W-1:0] ONE_Q   = MAG_W'(1) << FRAC_BITS;
  localparam logic [ARG_W-1:0] ARG_MAX = ARG_W'(8) << ARG_FRAC;
  localparam int HALF_LSB = 1 << (TANH_FRAC - 1);

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 2'd0;

  localparam logic [63:0] TANH_Z = (64'd1 << 36) / 64'(TANH_ENTRIES);

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] raw;
    logic                    neg;
    logic                    bypass;
    logic [MAG_W-1:0]        kq;
    logic [MAG_W-1:0]        d;
  } side_t;

  typedef logic [TANH_ENTRIES:0][ROM_W-1:0] tanh_rom_t;

  function automatic logic [63:0] long_div(logic [63:0] n, logic [63:0] dd);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, dd}) begin
        r    = r - {1'b0, dd};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    logic [63:0] term;
    logic [63:0] u;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    tanh_rom_t   rom;
    term = 64'd1 << 32;
    u    = term;
    e    = 64'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      term = long_div((term * TANH_Z) >> 32, 64'(k));
      if (k[0]) begin
        u = u - term;
      end else begin
        u = u + term;
      end
    end
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      num              = (64'd1 << 32) - e;
      den              = (64'd1 << 32) + e;
      rom[IDX_W'(i)]   = ROM_W'(long_div((num << 16) + den, den * 64'd2));
      e                = (e * u) >> 32;
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

[design/tscl_div.sv]
// ----------------------------------------------------------------------------
// tscl_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module tscl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [tscl_pkg::NUM_W-1:0]    num,
  input  logic [tscl_pkg::DEN_W-1:0]    den,
  input  tscl_pkg::side_t               side_in,
  output logic                          out_valid,
  output logic [tscl_pkg::QUOT_W-1:0]   quot,
  output logic                          ovf,
  output tscl_pkg::side_t               side_out
);

  localparam int QW = tscl_pkg::QUOT_W;
  localparam int NW = tscl_pkg::NUM_W;
  localparam int DW = tscl_pkg::DEN_W;
  localparam int CW = tscl_pkg::CMP_W;

  logic            valid [0:QW-1];
  logic [NW-1:0]   rem   [0:QW-1];
  logic [QW-1:0]   q     [0:QW-1];
  logic [DW-1:0]   dv    [0:QW-1];
  logic            of    [0:QW-1];
  tscl_pkg::side_t sd    [0:QW-1];

  logic            v_i   [0:QW-1];
  logic [NW-1:0]   rem_i [0:QW-1];
  logic [QW-1:0]   q_i   [0:QW-1];
  logic [DW-1:0]   dv_i  [0:QW-1];
  logic            of_i  [0:QW-1];
  tscl_pkg::side_t sd_i  [0:QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int BIT = QW - 1 - s;
    logic [CW-1:0] trial;
    logic          fits;

    if (s == 0) begin : g_first
      assign v_i[s]   = in_valid;
      assign rem_i[s] = num;
      assign q_i[s]   = '0;
      assign dv_i[s]  = den;
      assign of_i[s]  = CW'(num >> QW) >= CW'(den);
      assign sd_i[s]  = side_in;
    end else begin : g_next
      assign v_i[s]   = valid[s-1];
      assign rem_i[s] = rem[s-1];
      assign q_i[s]   = q[s-1];
      assign dv_i[s]  = dv[s-1];
      assign of_i[s]  = of[s-1];
      assign sd_i[s]  = sd[s-1];
    end

    assign trial = CW'(dv_i[s]) << BIT;
    assign fits  = CW'(rem_i[s]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (adv) begin
        valid[s] <= v_i[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s] <= fits ? NW'(CW'(rem_i[s]) - trial) : rem_i[s];
        q[s]   <= q_i[s] | (fits ? (QW'(1) << BIT) : QW'(0));
        dv[s]  <= dv_i[s];
        of[s]  <= of_i[s];
        sd[s]  <= sd_i[s];
      end
    end
  end

  assign out_valid = valid[QW-1];
  assign quot      = q[QW-1];
  assign ovf       = of[QW-1];
  assign side_out  = sd[QW-1];

endmodule

[design/tanh_soft_clip_limiter.sv]
// ----------------------------------------------------------------------------
// tanh_soft_clip_limiter
// Streaming tanh soft limiter for signed Q1.15 samples with APB knee register.
// ----------------------------------------------------------------------------
// Takes one sample every clock while in_ready is high and passes it through
// the pipeline to the output: two front stages form the magnitude and the
// tanh argument operands, a 16-stage restoring divider produces the Q4.12
// argument, and six more stages do the table lookup, interpolation, scaling
// and sign restore before the output register. A one-entry skid buffer behind
// the output register keeps in_ready high while a result beat waits; in_ready
// drops only while that buffer is occupied, and then the whole pipeline holds.
// The knee register at byte address 0 is sampled as each sample enters.
module tanh_soft_clip_limiter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tscl_pkg::PADDR_W-1:0]           paddr,
  input  logic [tscl_pkg::PDATA_W-1:0]           pwdata,
  output logic [tscl_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tscl_pkg::SAMPLE_WIDTH-1:0] sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tscl_pkg::SAMPLE_WIDTH-1:0] sample_out
);

  localparam int SW     = tscl_pkg::SAMPLE_WIDTH;
  localparam int MW     = tscl_pkg::MAG_W;
  localparam int P_W    = tscl_pkg::ARG_W + tscl_pkg::IDX_W;
  localparam int PROD_W = tscl_pkg::ROM_W + tscl_pkg::TANH_FRAC;
  localparam int RND_W  = PROD_W + 1;
  localparam int T_W    = tscl_pkg::ROM_W + 1;
  localparam int DT_W   = MW + T_W;
  localparam int C_W    = MW + 2;
  localparam logic [SW-1:0] SAMPLE_MIN = SW'(1) << (SW - 1);
  localparam logic [MW-1:0] MAG_MAX    = tscl_pkg::ONE_Q - MW'(1);

  // configuration
  logic [tscl_pkg::THRESH_W-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tscl_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == tscl_pkg::ADDR_THRESHOLD) begin
      threshold <= pwdata[tscl_pkg::THRESH_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == tscl_pkg::ADDR_THRESHOLD) ?
                  tscl_pkg::PDATA_W'(threshold) : '0;

  // flow control
  logic          adv;
  logic          push;
  logic          out_v;
  logic [SW-1:0] out_data;
  logic          skid_v;
  logic [SW-1:0] skid_data;

  assign adv      = !skid_v;
  assign in_ready = adv;

  // stage 1: magnitude and knee
  logic          s1_v;
  logic [SW-1:0] s1_raw;
  logic          s1_neg;
  logic [MW-1:0] s1_mag;
  logic [MW-1:0] s1_kq;
  logic [SW-1:0] raw_c;
  logic          neg_c;

  assign raw_c = sample_in;
  assign neg_c = raw_c[SW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raw <= raw_c;
      s1_neg <= neg_c;
      s1_mag <= neg_c ? MW'(~raw_c + SW'(1)) : MW'(raw_c);
      s1_kq  <= MW'(threshold >> tscl_pkg::KNEE_RSH) << tscl_pkg::KNEE_LSH;
    end
  end

  // stage 2: divider operands
  logic                         s2_v;
  tscl_pkg::side_t              s2_side;
  logic [tscl_pkg::NUM_W-1:0]   s2_num;
  logic [tscl_pkg::DEN_W-1:0]   s2_den;
  logic [MW-1:0]                d_c;
  logic [MW-1:0]                excess_c;

  assign d_c      = tscl_pkg::ONE_Q - s1_kq;
  assign excess_c = s1_mag - s1_kq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side.raw    <= s1_raw;
      s2_side.neg    <= s1_neg;
      s2_side.bypass <= s1_mag <= s1_kq;
      s2_side.kq     <= s1_kq;
      s2_side.d      <= d_c;
      s2_num <= (tscl_pkg::NUM_W'(excess_c) << tscl_pkg::ARG_SHIFT) +
                tscl_pkg::NUM_W'(d_c);
      s2_den <= {d_c, 1'b0};
    end
  end

  // divider
  logic                         dv_v;
  logic [tscl_pkg::QUOT_W-1:0]  dv_q;
  logic                         dv_ovf;
  tscl_pkg::side_t              dv_side;

  tscl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s2_v),
    .num      (s2_num),
    .den      (s2_den),
    .side_in  (s2_side),
    .out_valid(dv_v),
    .quot     (dv_q),
    .ovf      (dv_ovf),
    .side_out (dv_side)
  );

  // stage 3: saturate argument, table index and fraction
  logic                            s3_v;
  tscl_pkg::side_t                 s3_side;
  logic [tscl_pkg::IDX_W-1:0]      s3_idx;
  logic [tscl_pkg::TANH_FRAC-1:0]  s3_fr;
  logic [tscl_pkg::ARG_W-1:0]      arg_c;
  logic [P_W-1:0]                  p_c;

  assign arg_c = (dv_ovf || dv_q > tscl_pkg::QUOT_W'(tscl_pkg::ARG_MAX)) ?
                 tscl_pkg::ARG_MAX : tscl_pkg::ARG_W'(dv_q);
  assign p_c   = P_W'(arg_c) * P_W'(tscl_pkg::TANH_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side <= dv_side;
      s3_idx  <= tscl_pkg::IDX_W'(p_c >> tscl_pkg::TANH_FRAC);
      s3_fr   <= p_c[tscl_pkg::TANH_FRAC-1:0];
    end
  end

  // stage 4: table lookup
  logic                            s4_v;
  tscl_pkg::side_t                 s4_side;
  logic [tscl_pkg::ROM_W-1:0]      s4_lo;
  logic [tscl_pkg::ROM_W-1:0]      s4_diff;
  logic [tscl_pkg::TANH_FRAC-1:0]  s4_fr;
  logic [tscl_pkg::ROM_W-1:0]      lo_c;
  logic [tscl_pkg::ROM_W-1:0]      hi_c;
  logic [tscl_pkg::IDX_W-1:0]      idx_hi_c;

  assign idx_hi_c = s3_idx + tscl_pkg::IDX_W'(1);

  always_comb begin
    if (s3_idx >= tscl_pkg::IDX_W'(tscl_pkg::TANH_ENTRIES)) begin
      lo_c = tscl_pkg::TANH_ROM[tscl_pkg::TANH_ENTRIES];
      hi_c = tscl_pkg::TANH_ROM[tscl_pkg::TANH_ENTRIES];
    end else begin
      lo_c = tscl_pkg::TANH_ROM[s3_idx];
      hi_c = tscl_pkg::TANH_ROM[idx_hi_c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side <= s3_side;
      s4_lo   <= lo_c;
      s4_diff <= (hi_c >= lo_c) ? hi_c - lo_c : '0;
      s4_fr   <= s3_fr;
    end
  end

  // stage 5: interpolation product
  logic                        s5_v;
  tscl_pkg::side_t             s5_side;
  logic [tscl_pkg::ROM_W-1:0]  s5_lo;
  logic [PROD_W-1:0]           s5_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side <= s4_side;
      s5_lo   <= s4_lo;
      s5_prod <= PROD_W'(s4_diff) * PROD_W'(s4_fr);
    end
  end

  // stage 6: interpolated tanh
  logic             s6_v;
  tscl_pkg::side_t  s6_side;
  logic [T_W-1:0]   s6_t;
  logic [RND_W-1:0] prod_rnd_c;

  assign prod_rnd_c = RND_W'(s5_prod) + RND_W'(tscl_pkg::HALF_LSB);

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side <= s5_side;
      s6_t    <= T_W'(s5_lo) + T_W'(prod_rnd_c >> tscl_pkg::TANH_FRAC);
    end
  end

  // stage 7: scale by headroom
  logic             s7_v;
  tscl_pkg::side_t  s7_side;
  logic [DT_W-1:0]  s7_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side <= s6_side;
      s7_dt   <= DT_W'(s6_side.d) * DT_W'(s6_t);
    end
  end

  // stage 8: add knee, saturate, restore sign
  logic              s8_v;
  logic [SW-1:0]     s8_res;
  logic [DT_W:0]     dt_rnd_c;
  logic [C_W-1:0]    c_sum_c;
  logic [MW-1:0]     c_mag_c;
  logic [SW-1:0]     res_c;

  assign dt_rnd_c = (DT_W + 1)'(s7_dt) + (DT_W + 1)'(tscl_pkg::HALF_LSB);
  assign c_sum_c  = C_W'(s7_side.kq) + C_W'(dt_rnd_c >> tscl_pkg::TANH_FRAC);
  assign c_mag_c  = (c_sum_c > C_W'(MAG_MAX)) ? MAG_MAX : MW'(c_sum_c);

  always_comb begin
    if (s7_side.bypass) begin
      res_c = s7_side.raw;
    end else if (s7_side.neg) begin
      res_c = SW'(~c_mag_c + MW'(1));
    end else begin
      res_c = SW'(c_mag_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (adv) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_res <= res_c;
    end
  end

  // output register and skid buffer
  assign push = adv && s8_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || out_ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || out_ready) begin
      if (skid_v) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= s8_res;
      end
    end else if (push) begin
      skid_data <= s8_res;
    end
  end

  assign out_valid  = out_v;
  assign sample_out = out_data;

  a_no_min_out: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_data != SAMPLE_MIN))
    else $error("limited sample reached most negative code");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_v && !out_ready))
    else $error("skid filled while output beat was free to move");

endmodule
